FILE: sv/dmsrt_pkg.sv
// shared types and codes for the direct-mapped search result table
package dmsrt_pkg;

  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_PROBE = 1'b1;

  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_UPPER = 2'd1;
  localparam logic [1:0] BOUND_LOWER = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [63:0]        position_key;
    logic [15:0]        move_code;
    logic signed [15:0] entry_value;
    logic [7:0]         search_depth;
    logic [1:0]         bound_kind;
    logic signed [15:0] window_low;
    logic signed [15:0] window_high;
  } in_item_t;

  typedef struct packed {
    logic               key_hit;
    logic [15:0]        hit_move;
    logic               value_usable;
    logic signed [15:0] usable_value;
  } out_item_t;

  // one table slot as kept in memory
  typedef struct packed {
    logic               valid;
    logic [63:0]        tag;
    logic [15:0]        move;
    logic signed [15:0] value;
    logic [7:0]         depth;
    logic [1:0]         bound;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STORE,
    S_READ,
    S_EVAL
  } state_t;

  typedef struct packed {
    logic load_item;
    logic mem_clear;
    logic mem_write;
    logic mem_read;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_is_probe;
    logic clear_last;
    logic out_busy;
  } dp_stat_t;

endpackage

FILE: sv/direct_mapped_search_result_table_core.sv
// store: the input transfer, then the slot write. probe: the slot read is issued after
// the input transfer, the read data is registered, then the compare result is loaded
// into the output register once that is free. One item is in work at a time.
// the output register lets the next item transfer while a result waits.
// after reset a clearing pass zeroes every slot in turn; in_ready is low.
// TABLE_SLOTS must be a power of two; the slot is the low key bits.
module direct_mapped_search_result_table_core #(
  parameter int TABLE_SLOTS = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dmsrt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dmsrt_pkg::out_item_t out_data
);
  import dmsrt_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  dmsrt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dmsrt_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a usable score only ever comes with a key hit
  a_usable_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.value_usable |-> out_data.key_hit)
    else $error("usable score without key hit");

  // a miss reports zero move and zero score
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.key_hit |->
      (out_data.hit_move == '0) && (out_data.usable_value == '0) && !out_data.value_usable)
    else $error("miss with nonzero payload");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer while item in work");

  // a store never yields a result
  a_store_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode == MODE_STORE) && !out_valid |=> ##1 !out_valid)
    else $error("store produced a result");

endmodule

FILE: sv/dmsrt_ctrl.sv
// controller state machine: clearing pass, item sequencing, result hand-off
module dmsrt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dmsrt_pkg::dp_stat_t stat,
  output dmsrt_pkg::ctrl_cmd_t cmd
);
  import dmsrt_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.mem_clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_STORE;
        end
      end
      S_STORE: begin
        // item register holds the transfer; route on its mode
        if (stat.item_is_probe) begin
          cmd.mem_read = 1'b1;
          state_nxt    = S_EVAL;
        end else begin
          cmd.mem_write = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_nxt    = S_EVAL;
      end
      S_EVAL: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

FILE: sv/dmsrt_datapath.sv
// datapath: item register, slot memory, clear counter, probe evaluation, result register
module dmsrt_datapath #(
  parameter int TABLE_SLOTS = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dmsrt_pkg::ctrl_cmd_t cmd,
  output dmsrt_pkg::dp_stat_t  stat,
  input  dmsrt_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dmsrt_pkg::out_item_t out_data
);
  import dmsrt_pkg::*;

  localparam int SLOT_BITS = $clog2(TABLE_SLOTS);

  entry_t                 mem [TABLE_SLOTS];
  in_item_t               item_r;
  entry_t                 rd_data_r;
  logic [SLOT_BITS-1:0]   clr_cnt_r;
  logic                   out_valid_r;
  out_item_t              out_data_r;
  out_item_t              res_nxt;
  logic [SLOT_BITS-1:0]   wr_addr;
  entry_t                 wr_data;
  logic [SLOT_BITS-1:0]   slot_idx;

  assign slot_idx = item_r.position_key[SLOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.mem_clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_comb begin
    if (cmd.mem_clear) begin
      wr_addr = clr_cnt_r;
      wr_data = '0;
    end else begin
      wr_addr       = slot_idx;
      wr_data.valid = 1'b1;
      wr_data.tag   = item_r.position_key;
      wr_data.move  = item_r.move_code;
      wr_data.value = item_r.entry_value;
      wr_data.depth = item_r.search_depth;
      wr_data.bound = item_r.bound_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_clear || cmd.mem_write) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      rd_data_r <= mem[slot_idx];
    end
  end

  // probe result from the registered slot read
  always_comb begin
    res_nxt = '0;
    if (rd_data_r.valid && (rd_data_r.tag == item_r.position_key)) begin
      res_nxt.key_hit  = 1'b1;
      res_nxt.hit_move = rd_data_r.move;
      if (rd_data_r.depth >= item_r.search_depth) begin
        case (rd_data_r.bound)
          BOUND_EXACT: begin
            res_nxt.value_usable = 1'b1;
            res_nxt.usable_value = rd_data_r.value;
          end
          BOUND_UPPER: begin
            if (rd_data_r.value <= item_r.window_low) begin
              res_nxt.value_usable = 1'b1;
              res_nxt.usable_value = item_r.window_low;
            end
          end
          BOUND_LOWER: begin
            if (rd_data_r.value >= item_r.window_high) begin
              res_nxt.value_usable = 1'b1;
              res_nxt.usable_value = item_r.window_high;
            end
          end
          default: begin
            res_nxt.value_usable = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data           = out_data_r;
  assign stat.item_is_probe = (item_r.mode == MODE_PROBE);
  assign stat.clear_last    = (clr_cnt_r == SLOT_BITS'(TABLE_SLOTS - 1));
  assign stat.out_busy      = out_valid_r && !out_ready;

endmodule
